// File: hw/rtl/bci_pkg.sv
// Shared types, opcodes and constants of the byte-code instruction executor.
`timescale 1ns / 1ps
package bci_pkg;

    // default sizes
    localparam int unsigned MEM_BYTES_DEF = 65536;
    localparam int unsigned NUM_REGS_DEF  = 16;

    // configuration port address width (three 32-bit registers)
    localparam int unsigned CFG_AW = 4;

    // fixed register roles
    localparam int unsigned ADDR_REG = 8;   // base of load/store addresses
    localparam int unsigned TTY_REG  = 1;   // console byte source
    localparam int unsigned LINK_REG = 3;   // jal return address

    // encoded instruction lengths in bytes
    localparam logic [31:0] LEN_MEM = 32'd6;
    localparam logic [31:0] LEN_ADD = 32'd4;
    localparam logic [31:0] LEN_IMM = 32'd7;
    localparam logic [31:0] LEN_SYS = 32'd2;
    localparam logic [31:0] LEN_BAD = 32'd1;
    localparam logic [31:0] LEN_JAL = 32'd5;

    localparam logic [31:0] SYS_WRITE_RST = 32'd1;

    typedef enum logic [4:0] {
        FN_LW   = 5'd0,
        FN_LB   = 5'd2,
        FN_LI   = 5'd3,
        FN_SW   = 5'd4,
        FN_SB   = 5'd6,
        FN_ADD  = 5'd8,
        FN_ADDI = 5'd9,
        FN_BLT  = 5'd13,
        FN_BGT  = 5'd14,
        FN_BEQ  = 5'd15,
        FN_BNE  = 5'd16,
        FN_J    = 5'd17,
        FN_JR   = 5'd18,
        FN_JAL  = 5'd19,
        FN_SYS  = 5'd20
    } t_func;

    typedef enum logic [1:0] {
        FLT_NONE    = 2'd0,
        FLT_OPCODE  = 2'd1,
        FLT_SYSCALL = 2'd2,
        FLT_ADDR    = 2'd3
    } t_fault;

    typedef enum logic [1:0] {
        REG_JUMP_BASE = 2'd0,
        REG_SYS_EXIT  = 2'd1,
        REG_SYS_WRITE = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic [31:0] jump_base;
        logic [31:0] sys_exit_code;
        logic [31:0] sys_write_code;
    } t_cfg;

    // per-bank write enables and a shared read enable for the data memory
    typedef struct packed {
        logic [3:0] we;
        logic       re;
    } t_mem_ctl;

endpackage

// File: hw/rtl/bci_in_if.sv
// Instruction channel: valid/ready plus the decoded instruction fields.
`timescale 1ns / 1ps
interface bci_in_if;
    logic        valid;
    logic        ready;
    logic [4:0]  func;
    logic [3:0]  reg_a;
    logic [3:0]  reg_b;
    logic [3:0]  reg_c;
    logic [31:0] imm;

    modport source (output valid, func, reg_a, reg_b, reg_c, imm, input ready);
    modport sink   (input valid, func, reg_a, reg_b, reg_c, imm, output ready);
endinterface

// File: hw/rtl/bci_out_if.sv
// Result channel: valid/ready plus the per-instruction result fields.
`timescale 1ns / 1ps
interface bci_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] next_pc;
    logic        wr_valid;
    logic [3:0]  wr_index;
    logic [31:0] wr_value;
    logic        tty_valid;
    logic [7:0]  tty_byte;
    logic        exited;
    logic [1:0]  fault;

    modport source (output valid, next_pc, wr_valid, wr_index, wr_value, tty_valid,
                     tty_byte, exited, fault, input ready);
    modport sink   (input valid, next_pc, wr_valid, wr_index, wr_value, tty_valid,
                     tty_byte, exited, fault, output ready);
endinterface

// File: hw/rtl/bci_cfg.sv
// APB-style configuration registers: jump base and the two syscall codes.
`timescale 1ns / 1ps
module bci_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bci_pkg::CFG_AW-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output bci_pkg::t_cfg               o_cfg
);
    import bci_pkg::*;

    t_cfg     r_cfg;
    t_cfg_reg sel;
    logic     wr_en;

    assign pready = 1'b1;
    assign sel    = t_cfg_reg'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    // register writes on the access beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.jump_base      <= '0;
            r_cfg.sys_exit_code  <= '0;
            r_cfg.sys_write_code <= SYS_WRITE_RST;
        end else if (wr_en) begin
            unique case (sel)
                REG_JUMP_BASE: r_cfg.jump_base      <= pwdata;
                REG_SYS_EXIT:  r_cfg.sys_exit_code  <= pwdata;
                REG_SYS_WRITE: r_cfg.sys_write_code <= pwdata;
                default: ;
            endcase
        end
    end

    // read mux; unmapped addresses read as zero
    always_comb begin
        unique case (sel)
            REG_JUMP_BASE: prdata = r_cfg.jump_base;
            REG_SYS_EXIT:  prdata = r_cfg.sys_exit_code;
            REG_SYS_WRITE: prdata = r_cfg.sys_write_code;
            default:       prdata = '0;
        endcase
    end
endmodule

// File: hw/rtl/bci_regs.sv
// Register file: synchronous memory with two read ports, valid bits and shadow copies.
`timescale 1ns / 1ps
module bci_regs #(
    parameter int unsigned NUM_REGS = bci_pkg::NUM_REGS_DEF,
    localparam int unsigned RIDX_W  = $clog2(NUM_REGS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_re,
    input  logic [RIDX_W-1:0] i_raddr_a,
    input  logic [RIDX_W-1:0] i_raddr_b,
    input  logic              i_we,
    input  logic [RIDX_W-1:0] i_waddr,
    input  logic [31:0]       i_wdata,
    output logic [31:0]       o_rdata_a,
    output logic [31:0]       o_rdata_b,
    output logic [31:0]       o_reg_addr,
    output logic [31:0]       o_reg_tty
);
    import bci_pkg::*;

    localparam logic [RIDX_W-1:0] IDX_ADDR = RIDX_W'(ADDR_REG % NUM_REGS);
    localparam logic [RIDX_W-1:0] IDX_TTY  = RIDX_W'(TTY_REG % NUM_REGS);

    logic [31:0]         r_mem [NUM_REGS];
    logic [NUM_REGS-1:0] r_valid;
    logic [31:0]         r_q_a;
    logic [31:0]         r_q_b;
    logic                r_ok_a;
    logic                r_ok_b;
    logic                r_byp_a;
    logic                r_byp_b;
    logic [31:0]         r_byp_data;
    logic [31:0]         r_reg_addr;
    logic [31:0]         r_reg_tty;

    // storage array: one write, two registered reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q_a      <= r_mem[i_raddr_a];
            r_q_b      <= r_mem[i_raddr_b];
            r_byp_data <= i_wdata;
        end
    end

    // written-entry flags, same-edge write bypass and shadows of fixed-role registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_ok_a     <= 1'b0;
            r_ok_b     <= 1'b0;
            r_byp_a    <= 1'b0;
            r_byp_b    <= 1'b0;
            r_reg_addr <= '0;
            r_reg_tty  <= '0;
        end else begin
            if (i_re) begin
                r_ok_a  <= r_valid[i_raddr_a];
                r_ok_b  <= r_valid[i_raddr_b];
                r_byp_a <= i_we && (i_waddr == i_raddr_a);
                r_byp_b <= i_we && (i_waddr == i_raddr_b);
            end
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
                if (i_waddr == IDX_ADDR) begin
                    r_reg_addr <= i_wdata;
                end
                if (i_waddr == IDX_TTY) begin
                    r_reg_tty <= i_wdata;
                end
            end
        end
    end

    // never-written entries read as zero
    assign o_rdata_a  = r_byp_a ? r_byp_data : (r_ok_a ? r_q_a : '0);
    assign o_rdata_b  = r_byp_b ? r_byp_data : (r_ok_b ? r_q_b : '0);
    assign o_reg_addr = r_reg_addr;
    assign o_reg_tty  = r_reg_tty;
endmodule

// File: hw/rtl/bci_dmem.sv
// Data memory: four byte-wide banks interleaved by address, with a clearing pass after reset.
`timescale 1ns / 1ps
module bci_dmem #(
    parameter int unsigned MEM_BYTES = bci_pkg::MEM_BYTES_DEF,
    localparam int unsigned ROW_W    = $clog2((MEM_BYTES + 3) / 4)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  bci_pkg::t_mem_ctl         i_ctl,
    input  logic [3:0][ROW_W-1:0]     i_row,
    input  logic [3:0][7:0]           i_wdata,
    output logic [3:0][7:0]           o_rdata,
    output logic                      o_busy
);
    import bci_pkg::*;

    localparam int unsigned       ROWS     = (MEM_BYTES + 3) / 4;
    localparam logic [ROW_W-1:0]  LAST_ROW = ROW_W'(ROWS - 1);

    logic             r_clr_active;
    logic [ROW_W-1:0] r_clr_row;

    // clearing pass: one row of all banks per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_row    <= '0;
        end else if (r_clr_active) begin
            if (r_clr_row == LAST_ROW) begin
                r_clr_active <= 1'b0;
            end
            r_clr_row <= r_clr_row + ROW_W'(1);
        end
    end

    assign o_busy = r_clr_active;

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [7:0]       r_mem [ROWS];
        logic [7:0]       r_q;
        logic             wr_en;
        logic [ROW_W-1:0] wr_row;
        logic [7:0]       wr_byte;

        assign wr_en   = r_clr_active || i_ctl.we[b];
        assign wr_row  = r_clr_active ? r_clr_row : i_row[b];
        assign wr_byte = r_clr_active ? 8'd0 : i_wdata[b];

        always_ff @(posedge i_clk) begin
            if (wr_en) begin
                r_mem[wr_row] <= wr_byte;
            end
            if (i_ctl.re) begin
                r_q <= r_mem[i_row[b]];
            end
        end

        assign o_rdata[b] = r_q;
    end
endmodule

// File: hw/rtl/byte_code_instruction_executor.sv
// Top level: three-stage instruction pipeline around the register file and data memory.
// Throughput: one instruction per cycle unless o_result.ready is held low; register read,
// execute/memory access and load writeback each take one stage, with forwarding from
// writeback into execute.
// Reset: synchronous; after release the data memory is cleared one row per cycle,
// (MEM_BYTES+3)/4 rows (16384 at the default size), and no instruction is accepted
// until the pass ends. Registers read as zero until first written.
`timescale 1ns / 1ps
module byte_code_instruction_executor #(
    parameter int unsigned MEM_BYTES = bci_pkg::MEM_BYTES_DEF,
    parameter int unsigned NUM_REGS  = bci_pkg::NUM_REGS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    bci_in_if.sink                      i_item,
    bci_out_if.source                   o_result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bci_pkg::CFG_AW-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import bci_pkg::*;

    localparam int unsigned        RIDX_W   = $clog2(NUM_REGS);
    localparam int unsigned        ROW_W    = $clog2((MEM_BYTES + 3) / 4);
    localparam logic [32:0]        MEM_LIM  = 33'(MEM_BYTES);
    localparam logic [RIDX_W:0]    NREG_X   = (RIDX_W + 1)'(NUM_REGS);
    localparam logic [RIDX_W-1:0]  IDX_ADDR = RIDX_W'(ADDR_REG % NUM_REGS);
    localparam logic [RIDX_W-1:0]  IDX_TTY  = RIDX_W'(TTY_REG % NUM_REGS);
    localparam logic [RIDX_W-1:0]  IDX_LINK = RIDX_W'(LINK_REG % NUM_REGS);

    // register index modulo NUM_REGS (index is below twice NUM_REGS)
    function automatic logic [RIDX_W-1:0] reg_sel(input logic [3:0] x);
        logic [RIDX_W:0] ext;
        ext = (RIDX_W + 1)'(x);
        if (ext >= NREG_X) begin
            ext = ext - NREG_X;
        end
        return ext[RIDX_W-1:0];
    endfunction

    t_cfg cfg;

    // handshake
    logic out_free, adv2, s2_free, adv1, s1_free, accept, mem_busy;

    // register file
    logic [31:0] rf_rdata_a, rf_rdata_b, rf_reg_addr, rf_reg_tty;

    // data memory
    t_mem_ctl              mem_ctl;
    logic [3:0][ROW_W-1:0] mem_row;
    logic [3:0][7:0]       mem_wdata;
    logic [3:0][7:0]       mem_rdata;
    logic [3:0]            s1_we;
    logic                  s1_re;

    // execute stage
    logic              r_s1_valid;
    logic [4:0]        r_s1_func;
    logic [RIDX_W-1:0] r_s1_ra, r_s1_rb, r_s1_rc;
    logic [31:0]       r_s1_imm;
    logic [31:0]       r_pc;
    logic              r_exit;

    // writeback stage
    logic              r_s2_valid;
    logic [31:0]       r_s2_npc;
    logic              r_s2_wv;
    logic [RIDX_W-1:0] r_s2_wi;
    logic [31:0]       r_s2_wval;
    logic              r_s2_load;
    logic              r_s2_word;
    logic [1:0]        r_s2_a0;
    logic              r_s2_tv;
    logic [7:0]        r_s2_tbyte;
    logic              r_s2_exited;
    t_fault            r_s2_fault;
    logic [31:0]       s2_wval;

    // output register
    logic              r_out_valid;
    logic [31:0]       r_out_npc;
    logic              r_out_wv;
    logic [3:0]        r_out_wi;
    logic [31:0]       r_out_wval;
    logic              r_out_tv;
    logic [7:0]        r_out_tbyte;
    logic              r_out_exited;
    t_fault            r_out_fault;

    // next values from execute
    logic [31:0]       n_pc;
    logic              n_exit;
    logic              n_s2_wv;
    logic [RIDX_W-1:0] n_s2_wi;
    logic [31:0]       n_s2_wval;
    logic              n_s2_load;
    logic              n_s2_word;
    logic              n_s2_tv;
    logic [7:0]        n_s2_tbyte;
    t_fault            n_s2_fault;

    // forwarded operands and addresses
    logic [31:0]       va, vb, reg_addr_f, reg_tty_f, addr, target;
    logic              word_ok, byte_ok;
    logic [1:0]        a0;
    logic [ROW_W-1:0]  row_base;

    bci_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    bci_regs #(.NUM_REGS(NUM_REGS)) u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_re       (accept),
        .i_raddr_a  (reg_sel(i_item.reg_a)),
        .i_raddr_b  (reg_sel(i_item.reg_b)),
        .i_we       (adv2 && r_s2_wv),
        .i_waddr    (r_s2_wi),
        .i_wdata    (s2_wval),
        .o_rdata_a  (rf_rdata_a),
        .o_rdata_b  (rf_rdata_b),
        .o_reg_addr (rf_reg_addr),
        .o_reg_tty  (rf_reg_tty)
    );

    bci_dmem #(.MEM_BYTES(MEM_BYTES)) u_dmem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mem_ctl),
        .i_row   (mem_row),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata),
        .o_busy  (mem_busy)
    );

    // pipeline flow: each stage moves when the one ahead is empty or moving
    assign out_free     = !r_out_valid || o_result.ready;
    assign adv2         = r_s2_valid && out_free;
    assign s2_free      = !r_s2_valid || adv2;
    assign adv1         = r_s1_valid && s2_free;
    assign s1_free      = !r_s1_valid || adv1;
    assign i_item.ready = s1_free && !mem_busy;
    assign accept       = i_item.valid && i_item.ready;

    // writeback value: load data assembled from the banks, else the value from execute
    always_comb begin
        s2_wval = r_s2_wval;
        if (r_s2_load) begin
            if (r_s2_word) begin
                for (int i = 0; i < 4; i++) begin
                    s2_wval[8*i +: 8] = mem_rdata[2'(r_s2_a0 + 2'(i))];
                end
            end else begin
                s2_wval = {24'd0, mem_rdata[r_s2_a0]};
            end
        end
    end

    // operand forwarding from the writeback stage
    always_comb begin
        va         = (r_s2_valid && r_s2_wv && r_s2_wi == r_s1_ra)  ? s2_wval : rf_rdata_a;
        vb         = (r_s2_valid && r_s2_wv && r_s2_wi == r_s1_rb)  ? s2_wval : rf_rdata_b;
        reg_addr_f = (r_s2_valid && r_s2_wv && r_s2_wi == IDX_ADDR) ? s2_wval : rf_reg_addr;
        reg_tty_f  = (r_s2_valid && r_s2_wv && r_s2_wi == IDX_TTY)  ? s2_wval : rf_reg_tty;
    end

    assign addr     = r_s1_imm + reg_addr_f;
    assign target   = r_s1_imm + cfg.jump_base;
    assign word_ok  = ({1'b0, addr} + 33'd4) <= MEM_LIM;
    assign byte_ok  = {1'b0, addr} < MEM_LIM;
    assign a0       = addr[1:0];
    assign row_base = addr[ROW_W+1:2];

    // bank addressing: byte i of an access lands in bank (a0 + i) mod 4
    always_comb begin
        logic [1:0] lane;
        logic [4:0] sh;
        for (int b = 0; b < 4; b++) begin
            lane         = 2'(b);
            sh           = {lane - a0, 3'b000};
            mem_row[b]   = row_base + ROW_W'(lane < a0);
            mem_wdata[b] = va[sh +: 8];
        end
    end

    assign mem_ctl.we = adv1 ? s1_we : 4'd0;
    assign mem_ctl.re = adv1 && s1_re;

    // execute: decode, compare, next pc, register write and memory request
    always_comb begin
        n_pc       = r_pc;
        n_exit     = r_exit;
        n_s2_wv    = 1'b0;
        n_s2_wi    = '0;
        n_s2_wval  = '0;
        n_s2_load  = 1'b0;
        n_s2_word  = 1'b0;
        n_s2_tv    = 1'b0;
        n_s2_tbyte = '0;
        n_s2_fault = FLT_NONE;
        s1_we      = 4'd0;
        s1_re      = 1'b0;
        if (!r_exit) begin
            unique case (t_func'(r_s1_func)) inside
                FN_LI: begin
                    n_pc      = r_pc + LEN_MEM;
                    n_s2_wv   = 1'b1;
                    n_s2_wi   = r_s1_ra;
                    n_s2_wval = r_s1_imm;
                end
                FN_LW: begin
                    n_pc = r_pc + LEN_MEM;
                    if (word_ok) begin
                        n_s2_wv   = 1'b1;
                        n_s2_wi   = r_s1_ra;
                        n_s2_load = 1'b1;
                        n_s2_word = 1'b1;
                        s1_re     = 1'b1;
                    end else begin
                        n_s2_fault = FLT_ADDR;
                    end
                end
                FN_LB: begin
                    n_pc = r_pc + LEN_MEM;
                    if (byte_ok) begin
                        n_s2_wv   = 1'b1;
                        n_s2_wi   = r_s1_ra;
                        n_s2_load = 1'b1;
                        s1_re     = 1'b1;
                    end else begin
                        n_s2_fault = FLT_ADDR;
                    end
                end
                FN_SW: begin
                    n_pc = r_pc + LEN_MEM;
                    if (word_ok) begin
                        s1_we = 4'hF;
                    end else begin
                        n_s2_fault = FLT_ADDR;
                    end
                end
                FN_SB: begin
                    n_pc = r_pc + LEN_MEM;
                    if (byte_ok) begin
                        s1_we = 4'b0001 << a0;
                    end else begin
                        n_s2_fault = FLT_ADDR;
                    end
                end
                FN_ADD: begin
                    n_pc      = r_pc + LEN_ADD;
                    n_s2_wv   = 1'b1;
                    n_s2_wi   = r_s1_rc;
                    n_s2_wval = va + vb;
                end
                FN_ADDI: begin
                    n_pc      = r_pc + LEN_IMM;
                    n_s2_wv   = 1'b1;
                    n_s2_wi   = r_s1_rb;
                    n_s2_wval = va + r_s1_imm;
                end
                FN_BLT, FN_BGT, FN_BEQ, FN_BNE: begin
                    logic taken;
                    unique case (t_func'(r_s1_func))
                        FN_BLT:  taken = va < vb;
                        FN_BGT:  taken = va > vb;
                        FN_BEQ:  taken = va == vb;
                        default: taken = va != vb;
                    endcase
                    n_pc = taken ? target : (r_pc + LEN_IMM);
                end
                FN_J: begin
                    n_pc = target;
                end
                FN_JR: begin
                    n_pc = va;
                end
                FN_JAL: begin
                    n_s2_wv   = 1'b1;
                    n_s2_wi   = IDX_LINK;
                    n_s2_wval = r_pc + LEN_JAL;
                    n_pc      = target;
                end
                FN_SYS: begin
                    n_pc = r_pc + LEN_SYS;
                    // exit takes priority when both codes match
                    if (va == cfg.sys_exit_code) begin
                        n_exit = 1'b1;
                    end else if (va == cfg.sys_write_code) begin
                        n_s2_tv    = 1'b1;
                        n_s2_tbyte = reg_tty_f[7:0];
                    end else begin
                        n_s2_fault = FLT_SYSCALL;
                    end
                end
                default: begin
                    n_pc       = r_pc + LEN_BAD;
                    n_s2_fault = FLT_OPCODE;
                end
            endcase
        end
    end

    // pipeline control, program counter and exit flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pc        <= '0;
            r_exit      <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (adv1) begin
                r_s1_valid <= 1'b0;
            end
            if (adv1) begin
                r_s2_valid <= 1'b1;
                r_pc       <= n_pc;
                r_exit     <= n_exit;
            end else if (adv2) begin
                r_s2_valid <= 1'b0;
            end
            if (adv2) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_func <= i_item.func;
            r_s1_ra   <= reg_sel(i_item.reg_a);
            r_s1_rb   <= reg_sel(i_item.reg_b);
            r_s1_rc   <= reg_sel(i_item.reg_c);
            r_s1_imm  <= i_item.imm;
        end
        if (adv1) begin
            r_s2_npc    <= n_pc;
            r_s2_wv     <= n_s2_wv;
            r_s2_wi     <= n_s2_wi;
            r_s2_wval   <= n_s2_wval;
            r_s2_load   <= n_s2_load;
            r_s2_word   <= n_s2_word;
            r_s2_a0     <= a0;
            r_s2_tv     <= n_s2_tv;
            r_s2_tbyte  <= n_s2_tbyte;
            r_s2_exited <= n_exit;
            r_s2_fault  <= n_s2_fault;
        end
        if (adv2) begin
            r_out_npc    <= r_s2_npc;
            r_out_wv     <= r_s2_wv;
            r_out_wi     <= 4'(r_s2_wi);
            r_out_wval   <= s2_wval;
            r_out_tv     <= r_s2_tv;
            r_out_tbyte  <= r_s2_tbyte;
            r_out_exited <= r_s2_exited;
            r_out_fault  <= r_s2_fault;
        end
    end

    // result beat
    assign o_result.valid     = r_out_valid;
    assign o_result.next_pc   = r_out_npc;
    assign o_result.wr_valid  = r_out_wv;
    assign o_result.wr_index  = r_out_wi;
    assign o_result.wr_value  = r_out_wval;
    assign o_result.tty_valid = r_out_tv;
    assign o_result.tty_byte  = r_out_tbyte;
    assign o_result.exited    = r_out_exited;
    assign o_result.fault     = r_out_fault;
endmodule

// File: bench/tb_byte_code_instruction_executor.sv
// Testbench for the byte-code instruction executor: random and directed programs checked in order.
`timescale 1ns / 1ps
module tb_byte_code_instruction_executor;
    import bci_pkg::*;

    localparam int unsigned MEM_SIZE    = MEM_BYTES_DEF;
    localparam logic [31:0] WORD_LAST   = MEM_SIZE - 4;
    // covers the memory clearing pass after reset plus the longest stalls
    localparam int          QUIET_LIMIT = 100000;

    typedef struct packed {
        logic [4:0]  func;
        logic [3:0]  ra;
        logic [3:0]  rb;
        logic [3:0]  rc;
        logic [31:0] imm;
    } t_insn;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        wr_valid;
        logic [3:0]  wr_index;
        logic [31:0] wr_value;
        logic        tty_valid;
        logic [7:0]  tty_byte;
        logic        exited;
        t_fault      fault;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    bci_in_if  insn_ch ();
    bci_out_if res_ch ();

    byte_code_instruction_executor u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (insn_ch),
        .o_result (res_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #2 i_clk = ~i_clk;

    // architectural shadow of the executor
    logic [31:0] arch_regs [16]      = '{default: 32'h0};
    logic [7:0]  arch_mem [MEM_SIZE] = '{default: 8'h00};
    logic [31:0] arch_pc             = 32'h0;
    logic        arch_exited         = 1'b0;
    t_cfg        arch_cfg;

    t_insn   insn_backlog [$];
    t_result results_due [$];
    int      mismatches   = 0;
    int      quiet_cycles = 0;
    int      src_idle_pct = 0;
    int      snk_stall_pct = 0;
    logic    in_fire = 1'b0;

    // executes one instruction on the shadow state and returns its result beat
    function automatic t_result execute_insn(t_insn insn);
        t_result     r;
        logic [31:0] pc;
        logic [31:0] addr;
        logic [31:0] va;
        logic [31:0] vb;
        logic        taken;
        r = '0;
        pc = arch_pc;
        addr = insn.imm + arch_regs[ADDR_REG];
        va = arch_regs[insn.ra];
        vb = arch_regs[insn.rb];
        taken = 1'b0;
        if (!arch_exited) begin
            case (insn.func) inside
                FN_LI: begin
                    pc = pc + LEN_MEM;
                    r.wr_valid = 1'b1;
                    r.wr_index = insn.ra;
                    r.wr_value = insn.imm;
                end
                FN_LW: begin
                    pc = pc + LEN_MEM;
                    if (addr <= WORD_LAST) begin
                        r.wr_valid = 1'b1;
                        r.wr_index = insn.ra;
                        r.wr_value = {arch_mem[addr + 3], arch_mem[addr + 2],
                                      arch_mem[addr + 1], arch_mem[addr]};
                    end else begin
                        r.fault = FLT_ADDR;
                    end
                end
                FN_LB: begin
                    pc = pc + LEN_MEM;
                    if (addr < MEM_SIZE) begin
                        r.wr_valid = 1'b1;
                        r.wr_index = insn.ra;
                        r.wr_value = {24'h0, arch_mem[addr]};
                    end else begin
                        r.fault = FLT_ADDR;
                    end
                end
                FN_SW: begin
                    pc = pc + LEN_MEM;
                    if (addr <= WORD_LAST) begin
                        arch_mem[addr]     = va[7:0];
                        arch_mem[addr + 1] = va[15:8];
                        arch_mem[addr + 2] = va[23:16];
                        arch_mem[addr + 3] = va[31:24];
                    end else begin
                        r.fault = FLT_ADDR;
                    end
                end
                FN_SB: begin
                    pc = pc + LEN_MEM;
                    if (addr < MEM_SIZE) arch_mem[addr] = va[7:0];
                    else r.fault = FLT_ADDR;
                end
                FN_ADD: begin
                    pc = pc + LEN_ADD;
                    r.wr_valid = 1'b1;
                    r.wr_index = insn.rc;
                    r.wr_value = va + vb;
                end
                FN_ADDI: begin
                    pc = pc + LEN_IMM;
                    r.wr_valid = 1'b1;
                    r.wr_index = insn.rb;
                    r.wr_value = va + insn.imm;
                end
                FN_BLT, FN_BGT, FN_BEQ, FN_BNE: begin
                    pc = pc + LEN_IMM;
                    case (insn.func)
                        FN_BLT:  taken = va < vb;
                        FN_BGT:  taken = va > vb;
                        FN_BEQ:  taken = va == vb;
                        default: taken = va != vb;
                    endcase
                    if (taken) pc = insn.imm + arch_cfg.jump_base;
                end
                FN_J: pc = insn.imm + arch_cfg.jump_base;
                FN_JR: pc = va;
                FN_JAL: begin
                    r.wr_valid = 1'b1;
                    r.wr_index = 4'(LINK_REG);
                    r.wr_value = pc + LEN_JAL;
                    pc = insn.imm + arch_cfg.jump_base;
                end
                FN_SYS: begin
                    pc = pc + LEN_SYS;
                    // exit takes priority when both codes match
                    if (va == arch_cfg.sys_exit_code) begin
                        arch_exited = 1'b1;
                    end else if (va == arch_cfg.sys_write_code) begin
                        r.tty_valid = 1'b1;
                        r.tty_byte = arch_regs[TTY_REG][7:0];
                    end else begin
                        r.fault = FLT_SYSCALL;
                    end
                end
                default: begin
                    pc = pc + LEN_BAD;
                    r.fault = FLT_OPCODE;
                end
            endcase
            if (r.wr_valid) arch_regs[r.wr_index] = r.wr_value;
            arch_pc = pc;
        end
        r.next_pc = arch_pc;
        r.exited = arch_exited;
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // register value for generated programs; never the exit code by accident
    function automatic logic [31:0] operand_value();
        logic [31:0] v;
        do begin
            case ($urandom_range(0, 3))
                0: v = 32'($urandom_range(0, 255));
                1: v = $urandom;
                2: begin
                    case ($urandom_range(0, 3))
                        0: v = 32'h0000_0000;
                        1: v = 32'hFFFF_FFFF;
                        2: v = 32'h8000_0000;
                        default: v = 32'h7FFF_FFFF;
                    endcase
                end
                default: v = arch_cfg.sys_write_code;
            endcase
        end while (v == arch_cfg.sys_exit_code);
        return v;
    endfunction

    task automatic push_insn(logic [4:0] f, logic [3:0] a, logic [3:0] b, logic [3:0] c,
                             logic [31:0] imm);
        insn_backlog.push_back('{f, a, b, c, imm});
    endtask

    // random program fragments, mostly well-formed sequences with random content
    task automatic queue_random(int n);
        int          target;
        int          mode;
        logic [4:0]  f;
        logic [3:0]  ra;
        logic [3:0]  rb;
        logic [31:0] base;
        logic [31:0] imm;
        logic [31:0] v;
        logic        legal;
        target = insn_backlog.size() + n;
        while (insn_backlog.size() < target) begin
            ra = 4'($urandom_range(0, 15));
            rb = 4'($urandom_range(0, 15));
            mode = $urandom_range(0, 99);
            if (mode < 12) begin
                push_insn(FN_LI, ra, rb, 4'($urandom_range(0, 15)), operand_value());
            end else if (mode < 40) begin
                // load/store: small window, memory edge, wrapped or wild address
                case ($urandom_range(0, 3))
                    0: f = FN_LW;
                    1: f = FN_LB;
                    2: f = FN_SW;
                    default: f = FN_SB;
                endcase
                mode = $urandom_range(0, 19);
                if (mode < 14) begin
                    base = 32'($urandom_range(0, 192));
                    imm = 32'($urandom_range(0, 63));
                end else if (mode < 17) begin
                    base = MEM_SIZE - 16;
                    imm = 32'($urandom_range(0, 23));
                end else if (mode < 19) begin
                    base = 32'hFFFF_FF00 + 32'($urandom_range(0, 255));
                    imm = 32'h100 + 32'($urandom_range(0, 63));
                end else begin
                    base = $urandom;
                    imm = $urandom;
                end
                if ($urandom_range(0, 9) < 8) push_insn(FN_LI, 4'(ADDR_REG), 4'd0, 4'd0, base);
                push_insn(f, ra, rb, 4'($urandom_range(0, 15)), imm);
            end else if (mode < 52) begin
                if ($urandom_range(0, 1) == 0) begin
                    push_insn(FN_ADD, ra, rb, 4'($urandom_range(0, 15)), $urandom);
                end else begin
                    push_insn(FN_ADDI, ra, rb, 4'($urandom_range(0, 15)), $urandom);
                end
            end else if (mode < 66) begin
                case ($urandom_range(0, 3))
                    0: f = FN_BLT;
                    1: f = FN_BGT;
                    2: f = FN_BEQ;
                    default: f = FN_BNE;
                endcase
                // operands close together so every outcome shows up
                if ($urandom_range(0, 2) == 0) begin
                    v = operand_value();
                    push_insn(FN_LI, ra, 4'd0, 4'd0, v);
                    push_insn(FN_LI, rb, 4'd0, 4'd0, v + 32'($urandom_range(0, 2)) - 32'd1);
                end
                push_insn(f, ra, rb, 4'($urandom_range(0, 15)), $urandom);
            end else if (mode < 74) begin
                case ($urandom_range(0, 2))
                    0: f = FN_J;
                    1: f = FN_JR;
                    default: f = FN_JAL;
                endcase
                push_insn(f, ra, rb, 4'($urandom_range(0, 15)), $urandom);
            end else if (mode < 88) begin
                // console write, sometimes an unknown call
                push_insn(FN_LI, 4'(TTY_REG), 4'd0, 4'd0, $urandom);
                if ($urandom_range(0, 4) != 0) v = arch_cfg.sys_write_code;
                else v = operand_value();
                push_insn(FN_LI, ra, 4'd0, 4'd0, v);
                push_insn(FN_SYS, ra, rb, 4'($urandom_range(0, 15)), $urandom);
            end else if (mode < 94) begin
                push_insn(FN_SYS, ra, rb, 4'($urandom_range(0, 15)), $urandom);
            end else begin
                do begin
                    f = 5'($urandom_range(0, 31));
                    case (f) inside
                        FN_LW, FN_LB, FN_LI, FN_SW, FN_SB, FN_ADD, FN_ADDI, FN_BLT, FN_BGT,
                        FN_BEQ, FN_BNE, FN_J, FN_JR, FN_JAL, FN_SYS: legal = 1'b1;
                        default: legal = 1'b0;
                    endcase
                end while (legal);
                push_insn(f, ra, rb, 4'($urandom_range(0, 15)), $urandom);
            end
        end
    endtask

    // write on the register port: setup phase, then access phase
    task automatic write_cfg(t_cfg_reg r, logic [31:0] v);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {r, 2'b00};
        pwdata <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (r)
            REG_JUMP_BASE: arch_cfg.jump_base = v;
            REG_SYS_EXIT:  arch_cfg.sys_exit_code = v;
            default:       arch_cfg.sys_write_code = v;
        endcase
    endtask

    task automatic apply_settings(int src_pct, int snk_pct, logic [31:0] jb, logic [31:0] ex,
                                  logic [31:0] wr);
        write_cfg(REG_JUMP_BASE, jb);
        write_cfg(REG_SYS_EXIT, ex);
        write_cfg(REG_SYS_WRITE, wr);
        src_idle_pct = src_pct;
        snk_stall_pct = snk_pct;
    endtask

    // every queued instruction sent and every result back, then a short pause
    task automatic wait_idle();
        while (insn_backlog.size() != 0 || insn_ch.valid || results_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // instruction driver and result-side stalls
    always @(negedge i_clk) begin
        t_insn nxt;
        if (!i_rst_n) begin
            insn_ch.valid <= 1'b0;
        end else if (!insn_ch.valid || in_fire) begin
            if (insn_backlog.size() != 0 && $urandom_range(1, 100) > src_idle_pct) begin
                nxt = insn_backlog.pop_front();
                insn_ch.valid <= 1'b1;
                insn_ch.func <= nxt.func;
                insn_ch.reg_a <= nxt.ra;
                insn_ch.reg_b <= nxt.rb;
                insn_ch.reg_c <= nxt.rc;
                insn_ch.imm <= nxt.imm;
            end else begin
                insn_ch.valid <= 1'b0;
            end
        end
        res_ch.ready <= ($urandom_range(1, 100) > snk_stall_pct);
    end

    // predict on each instruction beat, compare on each result beat
    always @(posedge i_clk) begin
        t_insn   seen;
        t_result want;
        in_fire <= insn_ch.valid && insn_ch.ready;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (results_due.size() == 0) begin
                $display("%0t: result beat with nothing expected, next_pc %0h", $time,
                         res_ch.next_pc);
                mismatches++;
            end else begin
                want = results_due.pop_front();
                check_field("next_pc", want.next_pc, res_ch.next_pc);
                check_field("wr_valid", 32'(want.wr_valid), 32'(res_ch.wr_valid));
                check_field("wr_index", 32'(want.wr_index), 32'(res_ch.wr_index));
                check_field("wr_value", want.wr_value, res_ch.wr_value);
                check_field("tty_valid", 32'(want.tty_valid), 32'(res_ch.tty_valid));
                check_field("tty_byte", 32'(want.tty_byte), 32'(res_ch.tty_byte));
                check_field("exited", 32'(want.exited), 32'(res_ch.exited));
                check_field("fault", 32'(want.fault), 32'(res_ch.fault));
            end
        end
        if (i_rst_n && insn_ch.valid && insn_ch.ready) begin
            seen.func = insn_ch.func;
            seen.ra = insn_ch.reg_a;
            seen.rb = insn_ch.reg_b;
            seen.rc = insn_ch.reg_c;
            seen.imm = insn_ch.imm;
            results_due.push_back(execute_insn(seen));
        end
    end

    // watchdog on cycles without any beat
    always @(posedge i_clk) begin
        if (!i_rst_n || (insn_ch.valid && insn_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        logic [31:0] jb;
        logic [31:0] ex;
        logic [31:0] wr;
        arch_cfg = '{32'h0, 32'h0, SYS_WRITE_RST};
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset-value settings written explicitly, exit code zero
        apply_settings(0, 0, 32'h0, 32'h0, SYS_WRITE_RST);
        push_insn(FN_LI, 4'd1, 4'd0, 4'd0, 32'h41);
        push_insn(FN_LI, 4'd2, 4'd0, 4'd0, SYS_WRITE_RST);
        push_insn(FN_SYS, 4'd2, 4'd0, 4'd0, 32'h0);                 // console byte
        push_insn(FN_LI, 4'd4, 4'd0, 4'd0, 32'hFFFF_FFFF);
        push_insn(FN_LI, 4'(ADDR_REG), 4'd0, 4'd0, 32'h0);
        push_insn(FN_SW, 4'd4, 4'd0, 4'd0, WORD_LAST);             // last word that fits
        push_insn(FN_LW, 4'd5, 4'd0, 4'd0, WORD_LAST);
        push_insn(FN_SW, 4'd4, 4'd0, 4'd0, WORD_LAST + 1);         // word past the end
        push_insn(FN_SB, 4'd1, 4'd0, 4'd0, MEM_SIZE - 1);          // last byte
        push_insn(FN_LB, 4'd6, 4'd0, 4'd0, MEM_SIZE - 1);
        push_insn(FN_LB, 4'd6, 4'd0, 4'd0, MEM_SIZE);              // byte past the end
        push_insn(FN_LW, 4'd7, 4'd0, 4'd0, 32'hFFFF_FFFF);
        push_insn(FN_ADD, 4'd4, 4'd1, 4'd15, 32'h0);               // wraps to 0x40
        push_insn(FN_ADDI, 4'd4, 4'd9, 4'd0, 32'h1);
        push_insn(FN_BLT, 4'd1, 4'd4, 4'd0, 32'hFFFF_FFFF);        // taken
        push_insn(FN_BGT, 4'd1, 4'd4, 4'd0, 32'h10);               // not taken
        push_insn(FN_BEQ, 4'd0, 4'd0, 4'd0, 32'h100);
        push_insn(FN_BNE, 4'd0, 4'd0, 4'd0, 32'h200);
        push_insn(FN_J, 4'd0, 4'd0, 4'd0, 32'h1234);
        push_insn(FN_JAL, 4'd0, 4'd0, 4'd0, 32'h2000);
        push_insn(FN_JR, 4'(LINK_REG), 4'd0, 4'd0, 32'h0);
        push_insn(FN_LI, 4'd9, 4'd0, 4'd0, 32'h7777);
        push_insn(FN_SYS, 4'd9, 4'd0, 4'd0, 32'h0);                 // unknown call
        push_insn(5'h1F, 4'hF, 4'hF, 4'hF, 32'hFFFF_FFFF);         // illegal opcodes
        push_insn(5'h01, 4'h0, 4'h0, 4'h0, 32'h0);
        wait_idle();

        apply_settings(0, 0, 32'hFFFF_FFFF, 32'h3C5A_96E1, 32'h0);
        queue_random(210);
        wait_idle();

        jb = $urandom;
        ex = $urandom | 32'h0100_0000;
        wr = $urandom;
        if (wr == ex) wr = ~ex;
        apply_settings(63, 0, jb, ex, wr);
        queue_random(210);
        wait_idle();

        apply_settings(0, 63, 32'h100, 32'hA5C3_0F1E, 32'hFFFF_FFFF);
        queue_random(210);
        wait_idle();

        jb = $urandom;
        ex = $urandom | 32'h0100_0000;
        wr = $urandom;
        if (wr == ex) wr = ~ex;
        apply_settings(37, 37, jb, ex, wr);
        queue_random(210);
        wait_idle();

        // both call codes equal: exit wins, later instructions are ignored
        apply_settings(0, 0, 32'h40, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_insn(FN_LI, 4'd10, 4'd0, 4'd0, 32'hFFFF_FFFF);
        push_insn(FN_LI, 4'(TTY_REG), 4'd0, 4'd0, 32'h5A);
        push_insn(FN_SYS, 4'd10, 4'd0, 4'd0, 32'h0);
        push_insn(FN_LI, 4'd11, 4'd0, 4'd0, 32'h5);
        push_insn(FN_SYS, 4'd10, 4'd0, 4'd0, 32'h0);
        push_insn(5'h1F, 4'd0, 4'd0, 4'd0, 32'h0);
        wait_idle();
        repeat (8) @(posedge i_clk);

        if (mismatches == 0 && results_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
